>>> hdl/button_press_classifier_macros.svh
// Assertion macros shared by the button press classifier RTL.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpc assertion failed");

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpc assertion failed");

`endif

>>> hdl/bpc_pkg.sv
// Shared widths, register indexes and bundle types of the button press classifier.
`default_nettype none
package bpc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int TIME_BITS  = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_LOW   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_MAX_MS = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_MIN_MS  = CFG_IDX_BITS'(2);

    localparam logic [TIME_BITS-1:0] SHORT_MAX_RESET = TIME_BITS'(500);
    localparam logic [TIME_BITS-1:0] LONG_MIN_RESET  = TIME_BITS'(2000);

    typedef struct packed {
        logic                 active_low;
        logic [TIME_BITS-1:0] short_max_ms;
        logic [TIME_BITS-1:0] long_min_ms;
    } t_cfg;

    typedef struct packed {
        logic                  pressed;
        logic                  press_edge;
        logic                  release_edge;
        logic [COUNT_BITS-1:0] press_count;
        logic [COUNT_BITS-1:0] release_count;
        logic [TIME_BITS-1:0]  press_ms;
        logic [TIME_BITS-1:0]  release_ms;
        logic [COUNT_BITS-1:0] short_count;
        logic                  short_edge;
        logic [COUNT_BITS-1:0] long_count;
        logic                  long_edge;
    } t_result;

endpackage
`default_nettype wire

>>> hdl/bpc_cfg.sv
// Configuration register file: polarity and the short and long press thresholds.
`default_nettype none
module bpc_cfg
    import bpc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [TIME_BITS-1:0]    i_cfg_data,
    output t_cfg                         o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low   <= 1'b1;
            r_cfg.short_max_ms <= SHORT_MAX_RESET;
            r_cfg.long_min_ms  <= LONG_MIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACTIVE_LOW:   r_cfg.active_low   <= i_cfg_data[0];
                CFG_SHORT_MAX_MS: r_cfg.short_max_ms <= i_cfg_data;
                CFG_LONG_MIN_MS:  r_cfg.long_min_ms  <= i_cfg_data;
                default: ;  // unused index: drop the write
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> hdl/bpc_core.sv
// Press tracking state and the single-pass classifier logic for one sample.
`default_nettype none
module bpc_core
    import bpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_advance,
    input  wire logic                 i_pin,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire logic                 i_clr,
    output t_result                   o_res
);

    logic                  r_was_pressed;
    logic [TIME_BITS-1:0]  r_press_start;
    logic [TIME_BITS-1:0]  r_press_stop;
    logic                  r_press_running;
    logic [TIME_BITS-1:0]  r_release_start;
    logic                  r_released_once;
    logic [COUNT_BITS-1:0] r_presses;
    logic [COUNT_BITS-1:0] r_releases;
    logic [COUNT_BITS-1:0] r_short;
    logic                  r_short_win;
    logic [COUNT_BITS-1:0] r_long;
    logic                  r_long_hold;

    logic                  pressed;
    logic                  p_edge;
    logic                  r_edge;
    logic [TIME_BITS-1:0]  n_press_start;
    logic [TIME_BITS-1:0]  n_press_stop;
    logic                  n_press_running;
    logic [TIME_BITS-1:0]  n_release_start;
    logic                  n_released_once;
    logic [COUNT_BITS-1:0] n_presses;
    logic [COUNT_BITS-1:0] n_releases;
    logic [TIME_BITS-1:0]  press_ms;
    logic [TIME_BITS-1:0]  release_ms;
    logic                  hold;
    logic                  l_edge;
    logic [COUNT_BITS-1:0] n_long;
    logic [COUNT_BITS-1:0] short_kept;
    logic                  win;
    logic                  s_edge;
    logic [COUNT_BITS-1:0] n_short;

    always_comb begin
        pressed = i_cfg.active_low ? !i_pin : i_pin;
        p_edge  = pressed && !r_was_pressed;
        r_edge  = !pressed && r_was_pressed;

        n_press_start   = p_edge ? i_now : r_press_start;
        n_press_stop    = r_edge ? i_now : r_press_stop;
        n_press_running = p_edge ? 1'b1 : (r_edge ? 1'b0 : r_press_running);
        n_release_start = r_edge ? i_now : r_release_start;
        n_released_once = r_released_once || r_edge;
        n_presses       = p_edge ? r_presses + COUNT_ONE : r_presses;
        n_releases      = r_edge ? r_releases + COUNT_ONE : r_releases;

        // Durations wrap with the timestamp.
        press_ms   = n_press_running ? (i_now - n_press_start)
                                     : (n_press_stop - n_press_start);
        release_ms = (!pressed && n_released_once) ? (i_now - n_release_start)
                                                   : '0;

        hold   = pressed && (press_ms >= i_cfg.long_min_ms);
        l_edge = hold && !r_long_hold;
        n_long = l_edge ? r_long + COUNT_ONE : r_long;
        if (!pressed && (press_ms <= i_cfg.long_min_ms)) begin
            n_long = '0;
        end

        // A hold that reaches the short limit ends the run of short presses.
        short_kept = (pressed && (press_ms >= i_cfg.short_max_ms)) ? '0 : r_short;
        win        = !pressed && (press_ms <= i_cfg.short_max_ms);
        s_edge     = win && !r_short_win;
        n_short    = s_edge ? short_kept + COUNT_ONE : short_kept;

        o_res.pressed       = pressed;
        o_res.press_edge    = p_edge;
        o_res.release_edge  = r_edge;
        o_res.press_count   = n_presses;
        o_res.release_count = n_releases;
        o_res.press_ms      = press_ms;
        o_res.release_ms    = release_ms;
        o_res.short_count   = n_short;
        o_res.short_edge    = s_edge;
        o_res.long_count    = n_long;
        o_res.long_edge     = l_edge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_pressed   <= 1'b0;
            r_press_start   <= '0;
            r_press_stop    <= '0;
            r_press_running <= 1'b1;
            r_release_start <= '0;
            r_released_once <= 1'b0;
            r_presses       <= '0;
            r_releases      <= '0;
            r_short         <= '0;
            r_short_win     <= 1'b1;
            r_long          <= '0;
            r_long_hold     <= 1'b0;
        end else if (i_advance) begin
            r_was_pressed   <= pressed;
            r_press_start   <= n_press_start;
            r_press_stop    <= n_press_stop;
            r_press_running <= n_press_running;
            r_release_start <= n_release_start;
            r_released_once <= n_released_once;
            // Counts go out before the clear takes hold.
            r_presses       <= i_clr ? '0 : n_presses;
            r_releases      <= i_clr ? '0 : n_releases;
            r_short         <= n_short;
            r_short_win     <= win;
            r_long          <= n_long;
            r_long_hold     <= hold;
        end
    end

endmodule
`default_nettype wire

>>> hdl/button_press_classifier.sv
// Top level of the button press classifier: input stage, classifier and result stage.
//
// Input channel: one beat per button sample (i_pin_level, i_now_ms, i_clear_counts),
// accepted when i_in_valid and o_in_ready are both high.
// Output channel: one result beat per sample, in order, taken when o_out_valid
// and i_out_ready are both high.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 polarity,
// 1 short press limit, 2 long press limit); other indexes are dropped. Write
// only while no sample is in flight.
// Flow: an accepted sample is held in the input register, classified from there,
// and its result is loaded into the result register when the beat advances.
// Throughput: one sample per cycle while i_out_ready stays high; the classifier
// state updates when a beat moves from the input register to the result register.
// Stall: while the result register holds an untaken beat, the input register
// keeps one more sample, then o_in_ready drops until the receiver takes a beat.
// Reset: synchronous, active low; both registers empty, configuration back to
// active low polarity, 500 ms and 2000 ms, all counters and timer start stamps zero.
`default_nettype none
`include "button_press_classifier_macros.svh"
module button_press_classifier
    import bpc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [TIME_BITS-1:0]    i_cfg_data,
    input  wire logic                    i_in_valid,
    output      logic                    o_in_ready,
    input  wire logic                    i_pin_level,
    input  wire logic [TIME_BITS-1:0]    i_now_ms,
    input  wire logic                    i_clear_counts,
    output      logic                    o_out_valid,
    input  wire logic                    i_out_ready,
    output      logic                    o_pressed,
    output      logic                    o_press_edge,
    output      logic                    o_release_edge,
    output      logic [COUNT_BITS-1:0]   o_press_count,
    output      logic [COUNT_BITS-1:0]   o_release_count,
    output      logic [TIME_BITS-1:0]    o_press_ms,
    output      logic [TIME_BITS-1:0]    o_release_ms,
    output      logic [COUNT_BITS-1:0]   o_short_count,
    output      logic                    o_short_edge,
    output      logic [COUNT_BITS-1:0]   o_long_count,
    output      logic                    o_long_edge
);

    t_cfg    cfg;
    t_result res;

    logic                 r_in_valid;
    logic                 r_pin;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_clr;
    logic                 r_out_valid;
    t_result              r_res;
    logic                 advance;
    logic                 in_take;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    bpc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bpc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_pin     (r_pin),
        .i_now     (r_now),
        .i_clr     (r_clr),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on a beat, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pin <= i_pin_level;
            r_now <= i_now_ms;
            r_clr <= i_clear_counts;
        end
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pressed       = r_res.pressed;
    assign o_press_edge    = r_res.press_edge;
    assign o_release_edge  = r_res.release_edge;
    assign o_press_count   = r_res.press_count;
    assign o_release_count = r_res.release_count;
    assign o_press_ms      = r_res.press_ms;
    assign o_release_ms    = r_res.release_ms;
    assign o_short_count   = r_res.short_count;
    assign o_short_edge    = r_res.short_edge;
    assign o_long_count    = r_res.long_count;
    assign o_long_edge     = r_res.long_edge;

    `BPC_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, advance, r_out_valid)
    `BPC_ASSERT_NOW(a_press_edge_level, i_clk, i_rst_n, r_out_valid && r_res.press_edge, r_res.pressed && r_res.release_ms == '0)
    `BPC_ASSERT_NOW(a_release_edge_zero, i_clk, i_rst_n, r_out_valid && r_res.release_edge, !r_res.pressed && r_res.release_ms == '0)
    `BPC_ASSERT_NOW(a_edges_exclusive, i_clk, i_rst_n, r_out_valid && r_res.short_edge, !r_res.pressed && !r_res.long_edge)

endmodule
`default_nettype wire

>>> tb/tb_button_press_classifier.sv
// Self-checking testbench for the button press classifier: predicts every result beat.
`default_nettype none
module tb_button_press_classifier
    import bpc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 10;
    localparam int IDLE_PCT      = 36;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int HOLD_AT       = 120;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int PHASE_ITEMS   = 150;
    localparam int WRAP_PAIRS    = 64;
    localparam int MAX_REPORTS   = 200;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = CFG_IDX_BITS'(3);

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [TIME_BITS-1:0]    i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_pin_level;
    logic [TIME_BITS-1:0]    i_now_ms;
    logic                    i_clear_counts;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_pressed;
    logic                    o_press_edge;
    logic                    o_release_edge;
    logic [COUNT_BITS-1:0]   o_press_count;
    logic [COUNT_BITS-1:0]   o_release_count;
    logic [TIME_BITS-1:0]    o_press_ms;
    logic [TIME_BITS-1:0]    o_release_ms;
    logic [COUNT_BITS-1:0]   o_short_count;
    logic                    o_short_edge;
    logic [COUNT_BITS-1:0]   o_long_count;
    logic                    o_long_edge;

    button_press_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pin_level     (i_pin_level),
        .i_now_ms        (i_now_ms),
        .i_clear_counts  (i_clear_counts),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pressed       (o_pressed),
        .o_press_edge    (o_press_edge),
        .o_release_edge  (o_release_edge),
        .o_press_count   (o_press_count),
        .o_release_count (o_release_count),
        .o_press_ms      (o_press_ms),
        .o_release_ms    (o_release_ms),
        .o_short_count   (o_short_count),
        .o_short_edge    (o_short_edge),
        .o_long_count    (o_long_count),
        .o_long_edge     (o_long_edge)
    );

    class button_tracker;
        bit                    active_low;
        logic [TIME_BITS-1:0]  short_max_ms;
        logic [TIME_BITS-1:0]  long_min_ms;
        bit                    was_pressed;
        bit                    press_running;
        bit                    released_once;
        bit                    short_window_prev;
        bit                    long_hold_prev;
        logic [TIME_BITS-1:0]  press_start;
        logic [TIME_BITS-1:0]  press_stop;
        logic [TIME_BITS-1:0]  release_start;
        logic [COUNT_BITS-1:0] presses;
        logic [COUNT_BITS-1:0] releases;
        logic [COUNT_BITS-1:0] short_presses;
        logic [COUNT_BITS-1:0] long_presses;
        t_result               awaited[$];
        int                    mismatches;
        int                    reports;

        function new();
            active_low        = 1'b1;
            short_max_ms      = SHORT_MAX_RESET;
            long_min_ms       = LONG_MIN_RESET;
            was_pressed       = 1'b0;
            press_running     = 1'b1;
            released_once     = 1'b0;
            short_window_prev = 1'b1;
            long_hold_prev    = 1'b0;
            press_start       = '0;
            press_stop        = '0;
            release_start     = '0;
            presses           = '0;
            releases          = '0;
            short_presses     = '0;
            long_presses      = '0;
            mismatches        = 0;
            reports           = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [TIME_BITS-1:0] data);
            unique case (idx)
                CFG_ACTIVE_LOW:   active_low   = data[0];
                CFG_SHORT_MAX_MS: short_max_ms = data;
                CFG_LONG_MIN_MS:  long_min_ms  = data;
                default: ;
            endcase
        endfunction

        function void take_sample(bit pin, logic [TIME_BITS-1:0] stamp, bit clr);
            t_result r;
            bit      pressed;
            bit      hold;
            bit      win;
            r            = '0;
            pressed      = active_low ? !pin : pin;
            r.pressed    = pressed;
            r.press_edge = pressed && !was_pressed;
            r.release_edge = !pressed && was_pressed;
            was_pressed  = pressed;
            if (r.press_edge) begin
                presses       = presses + COUNT_ONE;
                press_start   = stamp;
                press_running = 1'b1;
            end
            if (r.release_edge) begin
                releases      = releases + COUNT_ONE;
                release_start = stamp;
                released_once = 1'b1;
                press_stop    = stamp;
                press_running = 1'b0;
            end
            r.press_ms   = press_running ? stamp - press_start : press_stop - press_start;
            r.release_ms = (!pressed && released_once) ? stamp - release_start : '0;

            hold           = pressed && r.press_ms >= long_min_ms;
            r.long_edge    = hold && !long_hold_prev;
            long_hold_prev = hold;
            if (r.long_edge)
                long_presses = long_presses + COUNT_ONE;
            if (!pressed && r.press_ms <= long_min_ms)
                long_presses = '0;

            if (pressed && r.press_ms >= short_max_ms)
                short_presses = '0;
            win               = !pressed && r.press_ms <= short_max_ms;
            r.short_edge      = win && !short_window_prev;
            short_window_prev = win;
            if (r.short_edge)
                short_presses = short_presses + COUNT_ONE;

            r.press_count   = presses;
            r.release_count = releases;
            r.short_count   = short_presses;
            r.long_count    = long_presses;
            awaited.push_back(r);
            // counts in this beat are the ones before the clear
            if (clr) begin
                presses  = '0;
                releases = '0;
            end
        endfunction

        function void report(string what, logic [TIME_BITS-1:0] want, logic [TIME_BITS-1:0] got);
            mismatches++;
            if (reports < MAX_REPORTS) begin
                reports++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            end
        endfunction

        function void check_field(string what, logic [TIME_BITS-1:0] want,
                                  logic [TIME_BITS-1:0] got);
            if (want !== got)
                report(what, want, got);
        endfunction

        function void compare_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                report("unexpected beat, press_ms", 'x, got.press_ms);
                return;
            end
            want = awaited.pop_front();
            check_field("pressed", TIME_BITS'(want.pressed), TIME_BITS'(got.pressed));
            check_field("press_edge", TIME_BITS'(want.press_edge),
                        TIME_BITS'(got.press_edge));
            check_field("release_edge", TIME_BITS'(want.release_edge),
                        TIME_BITS'(got.release_edge));
            check_field("press_count", TIME_BITS'(want.press_count),
                        TIME_BITS'(got.press_count));
            check_field("release_count", TIME_BITS'(want.release_count),
                        TIME_BITS'(got.release_count));
            check_field("press_ms",      want.press_ms,      got.press_ms);
            check_field("release_ms",    want.release_ms,    got.release_ms);
            check_field("short_count", TIME_BITS'(want.short_count),
                        TIME_BITS'(got.short_count));
            check_field("short_edge", TIME_BITS'(want.short_edge),
                        TIME_BITS'(got.short_edge));
            check_field("long_count", TIME_BITS'(want.long_count),
                        TIME_BITS'(got.long_count));
            check_field("long_edge", TIME_BITS'(want.long_edge),
                        TIME_BITS'(got.long_edge));
        endfunction
    endclass

    button_tracker        tracker;
    bit                   steady;
    int                   sent;
    int                   cycles = 0;
    logic [TIME_BITS-1:0] clock_ms;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one sample beat; starts and ends at a falling edge.
    task automatic send_sample(input bit pin, input logic [TIME_BITS-1:0] stamp, input bit clr);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_pin_level    <= pin;
        i_now_ms       <= stamp;
        i_clear_counts <= clr;
        forever begin
            @(posedge i_clk);
            if (o_in_ready)
                break;
        end
        tracker.take_sample(pin, stamp, clr);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [TIME_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result beat is back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly whole press/release episodes timed around the limits, some raw noise.
    task automatic random_phase(input int n);
        int                   start;
        int                   mids;
        bit                   on;
        logic [TIME_BITS-1:0] dur;
        logic [TIME_BITS-1:0] off;
        logic [TIME_BITS-1:0] t0;
        logic [TIME_BITS-1:0] stamp;
        start = sent;
        while (sent - start < n) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    stamp = $urandom;
                    send_sample(1'($urandom_range(0, 1)), stamp, $urandom_range(0, 3) == 0);
                    clock_ms = stamp;
                end
            end else begin
                on = !tracker.active_low;
                case ($urandom_range(0, 9))
                    0:       dur = tracker.short_max_ms - 1;
                    1:       dur = tracker.short_max_ms;
                    2:       dur = tracker.short_max_ms + 1;
                    3:       dur = tracker.long_min_ms - 1;
                    4:       dur = tracker.long_min_ms;
                    5:       dur = tracker.long_min_ms + 1;
                    6:       dur = '0;
                    9:       dur = $urandom;
                    default: dur = $urandom_range(0, 3000);
                endcase
                t0 = clock_ms + $urandom_range(1, 50);
                send_sample(on, t0, $urandom_range(0, 29) == 0);
                off  = '0;
                mids = $urandom_range(0, 3);
                repeat (mids) begin
                    off = off + TIME_BITS'({$urandom, $urandom} %
                                           (64'(dur) - 64'(off) + 64'd1));
                    send_sample(on, t0 + off, $urandom_range(0, 29) == 0);
                end
                // hold exactly to the end so the long threshold can be hit on a press
                if ($urandom_range(0, 1))
                    send_sample(on, t0 + dur, $urandom_range(0, 29) == 0);
                stamp = t0 + dur;
                send_sample(!on, stamp, $urandom_range(0, 29) == 0);
                repeat ($urandom_range(0, 3)) begin
                    stamp = stamp + $urandom_range(0, 400);
                    send_sample(!on, stamp, $urandom_range(0, 29) == 0);
                end
                clock_ms = stamp;
            end
        end
    endtask

    initial begin : receiver
        int      taken;
        bit      held;
        t_result got;
        taken       = 0;
        held        = 1'b0;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            // hold off long enough that the input side backs up
            if (taken == HOLD_AT && !held) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got.pressed       = o_pressed;
                got.press_edge    = o_press_edge;
                got.release_edge  = o_release_edge;
                got.press_count   = o_press_count;
                got.release_count = o_release_count;
                got.press_ms      = o_press_ms;
                got.release_ms    = o_release_ms;
                got.short_count   = o_short_count;
                got.short_edge    = o_short_edge;
                got.long_count    = o_long_count;
                got.long_edge     = o_long_edge;
                tracker.compare_result(got);
                taken++;
            end
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        logic [TIME_BITS-1:0] t;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_pin_level    = 1'b0;
        i_now_ms       = '0;
        i_clear_counts = 1'b0;
        steady         = 1'b0;
        sent           = 0;
        clock_ms       = '0;
        tracker        = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset settings: low pin is pressed, 500 ms short, 2000 ms long.
        send_sample(1'b1, 32'd0, 1'b0);             // no release yet
        send_sample(1'b1, 32'd100, 1'b0);           // press timer runs from reset
        send_sample(1'b0, 32'd200, 1'b0);
        send_sample(1'b0, 32'd699, 1'b0);
        send_sample(1'b0, 32'd700, 1'b0);           // hold reaches short limit
        send_sample(1'b1, 32'd700, 1'b0);           // release right at short limit
        send_sample(1'b1, 32'd800, 1'b1);           // clear after this beat
        send_sample(1'b0, 32'hFFFF_FF00, 1'b0);
        send_sample(1'b0, 32'h0000_06CF, 1'b0);     // timer wraps, one short of long
        send_sample(1'b0, 32'h0000_06D0, 1'b0);     // exactly long
        send_sample(1'b1, 32'h0000_0000, 1'b0);     // release at timestamp zero
        send_sample(1'b1, 32'd50, 1'b0);
        send_sample(1'b0, 32'd60, 1'b1);
        send_sample(1'b0, 32'd60, 1'b0);
        send_sample(1'b1, 32'hFFFF_FFFF, 1'b1);
        send_sample(1'b0, 32'hFFFF_FFFF, 1'b0);
        send_sample(1'b1, 32'h0000_0000, 1'b0);
        clock_ms = '0;

        random_phase(PHASE_ITEMS);

        settle();
        set_reg(CFG_ACTIVE_LOW, '0);
        set_reg(CFG_SHORT_MAX_MS, $urandom_range(200, 800));
        set_reg(CFG_LONG_MIN_MS, $urandom_range(1000, 5000));
        random_phase(PHASE_ITEMS);

        settle();
        set_reg(CFG_ACTIVE_LOW, '1);
        set_reg(CFG_SHORT_MAX_MS, '0);
        set_reg(CFG_LONG_MIN_MS, '1);
        random_phase(PHASE_ITEMS);

        settle();
        set_reg(CFG_ACTIVE_LOW, '0);
        set_reg(CFG_SHORT_MAX_MS, '1);
        set_reg(CFG_LONG_MIN_MS, '0);
        random_phase(PHASE_ITEMS);

        // Back-to-back one-ms presses with no idling on either side.
        settle();
        set_reg(CFG_ACTIVE_LOW, '1);
        steady = 1'b1;
        t = clock_ms;
        for (int i = 0; i < WRAP_PAIRS; i++) begin
            send_sample(1'b0, t, 1'b0);
            send_sample(1'b1, t + 1, 1'b0);
            t = t + 2;
        end
        clock_ms = t;
        steady = 1'b0;

        settle();
        set_reg(CFG_SPARE_IDX, $urandom);
        set_reg(CFG_ACTIVE_LOW, $urandom);
        set_reg(CFG_SHORT_MAX_MS, $urandom);
        set_reg(CFG_LONG_MIN_MS, $urandom);
        random_phase(PHASE_ITEMS);

        settle();
        set_reg(CFG_ACTIVE_LOW, $urandom_range(0, 1));
        set_reg(CFG_SHORT_MAX_MS, 32'd3);
        set_reg(CFG_LONG_MIN_MS, 32'd7);
        random_phase(PHASE_ITEMS);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
+incdir+hdl
hdl/bpc_pkg.sv
hdl/bpc_cfg.sv
hdl/bpc_core.sv
hdl/button_press_classifier.sv
tb/tb_button_press_classifier.sv
